FILE: sv/fth_pkg.sv
package fth_pkg;

  // Binary32 field widths and limits.
  localparam int unsigned SINGLE_W     = 32;
  localparam int unsigned SINGLE_EXP_W = 8;
  localparam int unsigned SINGLE_FRC_W = 23;
  localparam int unsigned HALF_W       = 16;
  localparam int unsigned HALF_FRC_W   = 10;

  // Magnitude of a single infinity, and of the largest finite half (65504).
  localparam logic [30:0] SINGLE_INF_MAG = 31'h7f80_0000;
  localparam logic [30:0] MAX_HALF_MAG   = 31'h477f_e000;

  // Biased single exponents that bound the half ranges.
  // Below ZERO_EXP_LIMIT the value rounds to signed zero; up to SUB_EXP_LIMIT
  // the value lands in the half subnormal range.
  localparam logic [7:0] ZERO_EXP_LIMIT = 8'd102;
  localparam logic [7:0] SUB_EXP_LIMIT  = 8'd112;
  localparam logic [7:0] EXP_REBIAS     = 8'd112;
  localparam logic [7:0] SUB_SHIFT_BASE = 8'd126;

  // Largest finite half magnitude, and the half exponent that would overflow.
  localparam logic [14:0] HALF_MAX_MAG  = 15'h7bff;
  localparam logic [5:0]  HALF_EXP_OVF  = 6'd31;

  // Clamped and classified single, after the first stage.
  typedef struct packed {
    logic        sign;
    logic        zero;
    logic        sub;
    logic [5:0]  exp;
    logic [4:0]  shamt;
    logic [22:0] frac;
  } dec_t;

  // Truncated half fraction with its rounding decision, after the second stage.
  typedef struct packed {
    logic       sign;
    logic       zero;
    logic       sub;
    logic [5:0] exp;
    logic [9:0] q;
    logic       inc;
  } aln_t;

endpackage

FILE: sv/float32_to_half_saturating.sv
// Throughput: one beat per cycle while out_stall_i is low, set by three register
// stages (clamp and classify, align, round), each of which loads whenever it is
// empty or drains.
// Reset: asynchronous and active low; it clears the stage valid bits only,
// so the pipeline comes up empty.
module float32_to_half_saturating (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [fth_pkg::SINGLE_W-1:0]        single_bits_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [fth_pkg::HALF_W-1:0]          half_bits_o
);

  fth_pkg::dec_t dec;
  fth_pkg::aln_t aln;
  logic          dec_valid;
  logic          dec_stall;
  logic          aln_valid;
  logic          aln_stall;

  // Stage one: clamp and classify.
  fth_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .bits_i  (single_bits_i),
    .valid_o (dec_valid),
    .stall_i (dec_stall),
    .dec_o   (dec)
  );

  // Stage two: align the fraction and decide the rounding.
  fth_align u_align (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .stall_o (dec_stall),
    .dec_i   (dec),
    .valid_o (aln_valid),
    .stall_i (aln_stall),
    .aln_o   (aln)
  );

  // Stage three: round and pack into the output register.
  fth_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (aln_valid),
    .stall_o (aln_stall),
    .aln_i   (aln),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .half_o  (half_bits_o)
  );

endmodule

FILE: sv/fth_decode.sv
module fth_decode (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                stall_o,
  input  logic [fth_pkg::SINGLE_W-1:0]        bits_i,
  output logic                                valid_o,
  input  logic                                stall_i,
  output fth_pkg::dec_t                       dec_o
);

  logic          valid_q;
  fth_pkg::dec_t dec_q, dec_d;
  logic          load;
  logic [30:0]   mag;
  logic [31:0]   clamped;
  logic [7:0]    bexp;
  logic [7:0]    rebias;
  logic [7:0]    shift;

  // The stage takes a new beat unless it holds one that is stalled.
  assign stall_o = valid_q & stall_i;
  assign load    = ~stall_o;

  // Clamp to +-65504; every NaN becomes positive 65504.
  always_comb begin
    mag = bits_i[30:0];
    if (mag > fth_pkg::SINGLE_INF_MAG) begin
      clamped = {1'b0, fth_pkg::MAX_HALF_MAG};
    end else if (mag > fth_pkg::MAX_HALF_MAG) begin
      clamped = {bits_i[31], fth_pkg::MAX_HALF_MAG};
    end else begin
      clamped = bits_i;
    end
  end

  // Classify the exponent and work out the subnormal alignment shift.
  always_comb begin
    bexp         = clamped[30:23];
    rebias       = bexp - fth_pkg::EXP_REBIAS;
    shift        = fth_pkg::SUB_SHIFT_BASE - bexp;
    dec_d.sign   = clamped[31];
    dec_d.zero   = bexp < fth_pkg::ZERO_EXP_LIMIT;
    dec_d.sub    = bexp <= fth_pkg::SUB_EXP_LIMIT;
    dec_d.exp    = rebias[5:0];
    dec_d.shamt  = shift[4:0];
    dec_d.frac   = clamped[22:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && valid_i) begin
      dec_q <= dec_d;
    end
  end

  assign valid_o = valid_q;
  assign dec_o   = dec_q;

endmodule

FILE: sv/fth_align.sv
module fth_align (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          stall_o,
  input  fth_pkg::dec_t dec_i,
  output logic          valid_o,
  input  logic          stall_i,
  output fth_pkg::aln_t aln_o
);

  logic          valid_q;
  fth_pkg::aln_t aln_q, aln_d;
  logic          load;
  logic [23:0]   mant;
  logic [23:0]   shifted;
  logic [23:0]   low_mask;
  logic [4:0]    rpos;
  logic          rbit;
  logic          sticky;

  assign stall_o = valid_q & stall_i;
  assign load    = ~stall_o;

  // Split the fraction into kept bits, round bit and sticky bits.
  always_comb begin
    mant     = {1'b1, dec_i.frac};
    rpos     = dec_i.shamt - 5'd1;
    shifted  = mant >> dec_i.shamt;
    low_mask = (24'd1 << rpos) - 24'd1;
    if (dec_i.sub) begin
      aln_d.q = shifted[9:0];
      rbit    = mant[rpos];
      sticky  = |(mant & low_mask);
    end else begin
      aln_d.q = dec_i.frac[22:13];
      rbit    = dec_i.frac[12];
      sticky  = |dec_i.frac[11:0];
    end
    // Round to nearest; a tie goes to the even value.
    aln_d.inc  = rbit & (sticky | aln_d.q[0]);
    aln_d.sign = dec_i.sign;
    aln_d.zero = dec_i.zero;
    aln_d.sub  = dec_i.sub;
    aln_d.exp  = dec_i.exp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && valid_i) begin
      aln_q <= aln_d;
    end
  end

  assign valid_o = valid_q;
  assign aln_o   = aln_q;

endmodule

FILE: sv/fth_round.sv
module fth_round (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  fth_pkg::aln_t               aln_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output logic [fth_pkg::HALF_W-1:0]  half_o
);

  logic        valid_q;
  logic [15:0] half_q, half_d;
  logic        load;
  logic [10:0] qr;
  logic [5:0]  exp_r;

  assign stall_o = valid_q & stall_i;
  assign load    = ~stall_o;

  // Apply the rounding increment and assemble the half pattern.
  always_comb begin
    qr    = {1'b0, aln_i.q} + {10'd0, aln_i.inc};
    exp_r = aln_i.exp;
    if (aln_i.zero) begin
      half_d = {aln_i.sign, 15'd0};
    end else if (aln_i.sub) begin
      // A carry here yields the smallest normal on its own.
      half_d = {aln_i.sign, 4'd0, qr};
    end else begin
      if (qr[10]) begin
        exp_r = aln_i.exp + 6'd1;
      end
      if (exp_r >= fth_pkg::HALF_EXP_OVF) begin
        half_d = {aln_i.sign, fth_pkg::HALF_MAX_MAG};
      end else begin
        half_d = {aln_i.sign, exp_r[4:0], qr[9:0]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && valid_i) begin
      half_q <= half_d;
    end
  end

  assign valid_o = valid_q;
  assign half_o  = half_q;

endmodule

FILE: dv/testbench.sv
module testbench;

  localparam int unsigned IDLE_PCT    = 18;
  localparam int unsigned RANDOM_BEATS = 900;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_WAIT  = 10;

  // Tracks the half patterns still owed by the converter and checks each result beat.
  class half_tracker;
    logic [fth_pkg::HALF_W-1:0] pending_halves[$];
    int unsigned                mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Binary32 to binary16 with clamp to +-65504 and round to nearest, ties to even.
    function logic [fth_pkg::HALF_W-1:0] round_to_half(
      logic [fth_pkg::SINGLE_W-1:0] single
    );
      logic [fth_pkg::SINGLE_W-1:0] bits;
      logic                         sign;
      int                           e;
      int unsigned                  sh;
      logic [23:0]                  mant;
      logic [23:0]                  q;
      logic [23:0]                  rem;
      logic [23:0]                  tie;
      logic [10:0]                  nq;
      bits = single;
      // Any NaN becomes +65504; infinities and large values keep their sign.
      if (single[30:0] > fth_pkg::SINGLE_INF_MAG) begin
        bits = {1'b0, fth_pkg::MAX_HALF_MAG};
      end else if (single[30:0] > fth_pkg::MAX_HALF_MAG) begin
        bits = {single[31], fth_pkg::MAX_HALF_MAG};
      end
      sign = bits[31];
      e    = int'(bits[30:23]) - int'(fth_pkg::EXP_REBIAS);
      // Half subnormal range, or too small for any nonzero half.
      if (e <= 0) begin
        if (e < -10) return {sign, 15'd0};
        mant = {1'b1, bits[22:0]};
        sh   = 14 - e;
        q    = mant >> sh;
        rem  = mant & ((24'd1 << sh) - 24'd1);
        tie  = 24'd1 << (sh - 1);
        if (rem > tie || (rem == tie && q[0])) q = q + 24'd1;
        return {sign, q[14:0]};
      end
      // Normal range: drop 13 fraction bits, a carry out bumps the exponent.
      nq = {1'b0, bits[22:13]};
      if (bits[12:0] > 13'h1000 || (bits[12:0] == 13'h1000 && nq[0])) begin
        nq = nq + 11'd1;
        if (nq[10]) begin
          nq = '0;
          e++;
        end
      end
      if (e >= int'(fth_pkg::HALF_EXP_OVF)) return {sign, fth_pkg::HALF_MAX_MAG};
      return {sign, 5'(e), nq[9:0]};
    endfunction

    function void note_single(logic [fth_pkg::SINGLE_W-1:0] single);
      pending_halves.insert(pending_halves.size(), round_to_half(single));
    endfunction

    function void check_half(logic [fth_pkg::HALF_W-1:0] actual);
      logic [fth_pkg::HALF_W-1:0] expected;
      if (pending_halves.size() == 0) begin
        $error("half_bits: no result expected, actual %h", actual);
        mismatches++;
        return;
      end
      expected = pending_halves.pop_front();
      if (actual !== expected) begin
        $error("half_bits mismatch: expected %h, actual %h", expected, actual);
        mismatches++;
      end
    endfunction

    function int unsigned owed();
      return pending_halves.size();
    endfunction
  endclass

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         in_valid_i    = 1'b0;
  logic                         in_stall_o;
  logic [fth_pkg::SINGLE_W-1:0] single_bits_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i   = 1'b0;
  logic [fth_pkg::HALF_W-1:0]   half_bits_o;

  half_tracker book;
  logic        calm   = 1'b0;
  int unsigned cycles = 0;

  float32_to_half_saturating u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .single_bits_i(single_bits_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .half_bits_o  (half_bits_o)
  );

  always #5 clk_i = ~clk_i;

  // Run watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: check each accepted beat, then pick the next stall.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) book.check_half(half_bits_o);
    out_stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // Offer one binary32 beat, with random idle cycles ahead of it.
  task automatic send_single(input logic [fth_pkg::SINGLE_W-1:0] value);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    single_bits_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    book.note_single(value);
  endtask

  // Hold the input side until every owed result has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (book.owed() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [fth_pkg::SINGLE_W-1:0] directed[$];
    logic [fth_pkg::SINGLE_W-1:0] value;
    logic [7:0]                   ex;
    logic [23:0]                  mant;
    int unsigned                  sel;
    int unsigned                  sh;
    book = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zeros, subnormals, ties, rounding carries, saturation and NaNs.
    directed = '{
      32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807f_ffff, 32'h0080_0000,
      32'h3300_0000, 32'hb300_0001, 32'h3380_0000, 32'h33c0_0000, 32'h387f_f000,
      32'h3800_0000, 32'h3f80_0000, 32'h3f80_1000, 32'hbf80_3000, 32'h3fff_f000,
      32'h477f_e000, 32'hc77f_efff, 32'h477f_f000, 32'h7f80_0000, 32'hff80_0000,
      32'h7fc0_0000, 32'hffff_ffff, 32'h7f80_0001, 32'h7f7f_ffff, 32'h387f_ffff
    };
    foreach (directed[i]) send_single(directed[i]);

    // Random beats, mostly aimed at the exponents where the half range lives.
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i == RANDOM_BEATS / 2) drain_results();
      calm <= (i >= 600 && i < 750);
      sel   = $urandom_range(99);
      value = $urandom();
      if (sel < 35) begin
        // Exponents from below the subnormal range to past the clamp.
        value[30:23] = 8'($urandom_range(145, 98));
      end else if (sel < 55) begin
        // Exact ties in the normal range, and some just past the clamp.
        value[30:23] = 8'($urandom_range(143, 113));
        value[12:0]  = 13'h1000;
      end else if (sel < 70) begin
        // Exact ties in the subnormal range.
        ex   = 8'($urandom_range(112, 102));
        sh   = 126 - ex;
        mant = {1'b1, value[22:0]};
        mant = (mant & ~((24'd1 << sh) - 24'd1)) | (24'd1 << (sh - 1));
        value[30:23] = ex;
        value[22:0]  = mant[22:0];
      end else if (sel < 80) begin
        // Infinities and NaNs with random payloads.
        value[30:23] = 8'hff;
        if ($urandom_range(1) == 0) value[22:0] = '0;
      end else if (sel < 88) begin
        // Exponent field zero: single subnormals, and zero if the fraction is zero.
        value[30:23] = 8'h00;
      end
      send_single(value);
    end
    in_valid_i <= 1'b0;
    calm       <= 1'b0;

    // Let the pipeline empty, then give it time to show any stray beats.
    while (book.owed() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (book.mismatches == 0 && book.owed() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
